// ===== hw/rtl/stn_pkg.sv =====
// Shared types and byte constants for the source text normalizer.
// No dependencies; every other source file but stn_stream_if imports this package.
package stn_pkg;

	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;
	localparam logic [7:0] BYTE_SP = 8'h20;
	localparam logic [7:0] BYTE_EF = 8'hEF;
	localparam logic [7:0] BYTE_BB = 8'hBB;
	localparam logic [7:0] BYTE_BF = 8'hBF;
	localparam logic [7:0] BYTE_C2 = 8'hC2;
	localparam logic [7:0] BYTE_A0 = 8'hA0;
	localparam logic [7:0] BYTE_E2 = 8'hE2;
	localparam logic [7:0] BYTE_80 = 8'h80;
	localparam logic [7:0] BYTE_81 = 8'h81;
	localparam logic [7:0] BYTE_8D = 8'h8D;
	localparam logic [7:0] BYTE_AF = 8'hAF;
	localparam logic [7:0] BYTE_A8 = 8'hA8;
	localparam logic [7:0] BYTE_A9 = 8'hA9;

	// Most bytes one input can release.
	localparam int unsigned MAX_OUT = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       run_end;
		logic       stream_end;
	} out_item_t;

	// Everything one input produces; cnt of zero only occurs with last set.
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [1:0]              cnt;
		logic                    last;
	} grp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hw/rtl/stn_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Payload type comes from the instantiator, normally a stn_pkg struct.
interface stn_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/source_text_normalizer_unit.sv =====
// Top level of the source text normalizer: front matcher, group queue, back serializer.
// Depends on stn_pkg, stn_stream_if, stn_front, stn_queue and stn_back.
//
//   channel  dir  payload     transaction
//   in_ch    in   in_item_t   one raw byte, in_last marks stream end
//   out_ch   out  out_item_t  one normalized byte or a bare end marker
//
// The front end takes one byte per cycle while the queue has room and
// turns it into a group of zero to three result bytes in the same cycle.
// The back end sends one result per cycle while out_ch is ready; a group holds
// the queue head until its last result goes, so plain text moves one byte per cycle.
// Reset clears the matcher to idle at stream start and empties the queue.
// A stall on out_ch backs up into the queue; in_ch stalls only when it is full.
module source_text_normalizer_unit
	import stn_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	stn_stream_if.sink   in_ch,
	stn_stream_if.source out_ch
);

	// Front-to-queue handoff.
	logic      push;
	grp_t      push_grp;
	// Queue-to-back handoff.
	logic      pop;
	grp_t      head;
	q_status_t q_st;

	// Classify each byte and hold partial sequences.
	stn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_st     (q_st),
		.push     (push),
		.push_grp (push_grp)
	);

	// Decouple matcher from output stalls.
	stn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.q_st     (q_st)
	);

	// Serialize each group into result transactions.
	stn_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_st   (q_st),
		.pop    (pop),
		.out_ch (out_ch)
	);

`ifndef ASSERT_OFF
	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_st.full && q_st.empty))
		else $error("queue reports full and empty together");

	a_bare_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.data.out_valid) |-> out_ch.data.stream_end)
		else $error("bare marker without stream end");

	a_stream_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.stream_end) |-> out_ch.data.run_end)
		else $error("stream end without run end");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_st.full)
		else $error("push into full queue");
`endif

endmodule

// ===== hw/rtl/stn_front.sv =====
// Front end: accepts input bytes, runs the sequence matcher and builds one group per byte.
// Depends on stn_pkg and stn_stream_if.
module stn_front
	import stn_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	stn_stream_if.sink    in_ch,
	input  q_status_t     q_st,
	output logic          push,
	output grp_t          push_grp
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MARK1,
		PH_MARK2,
		PH_CR,
		PH_C2,
		PH_E2,
		PH_E280,
		PH_E281
	} phase_t;

	phase_t     phase_q, ph_n, ph_mid;
	logic       start_q;
	logic       accept;
	logic       fresh, fresh_first;
	logic [7:0] b;
	logic       last;
	logic [1:0] n;
	logic [MAX_OUT-1:0][7:0] e;

	assign b      = in_ch.data.in_byte;
	assign last   = in_ch.data.in_last;
	assign in_ch.ready = !q_st.full;
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		n           = 2'd0;
		e           = '0;
		ph_mid      = PH_IDLE;
		fresh       = 1'b0;
		fresh_first = 1'b0;
		unique case (phase_q)
			PH_MARK1: begin
				if (b == BYTE_BB) begin
					ph_mid = PH_MARK2;
				end else begin
					e[n] = BYTE_EF; n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			PH_MARK2: begin
				if (b != BYTE_BF) begin
					e[n] = BYTE_EF; n = n + 2'd1;
					e[n] = BYTE_BB; n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			PH_CR: begin
				e[n] = BYTE_LF; n = n + 2'd1;
				fresh = (b != BYTE_LF);
			end
			PH_C2: begin
				if (b == BYTE_A0) begin
					e[n] = BYTE_SP; n = n + 2'd1;
				end else begin
					e[n] = BYTE_C2; n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			PH_E2: begin
				if (b == BYTE_80) begin
					ph_mid = PH_E280;
				end else if (b == BYTE_81) begin
					ph_mid = PH_E281;
				end else begin
					e[n] = BYTE_E2; n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			PH_E280: begin
				if ((b >= BYTE_80 && b <= BYTE_8D) || b == BYTE_AF) begin
					e[n] = BYTE_SP; n = n + 2'd1;
				end else if (b == BYTE_A8 || b == BYTE_A9) begin
					e[n] = BYTE_LF; n = n + 2'd1;
				end else begin
					e[n] = BYTE_E2; n = n + 2'd1;
					e[n] = BYTE_80; n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			PH_E281: begin
				if (b == BYTE_A0) begin
					e[n] = BYTE_SP; n = n + 2'd1;
				end else begin
					e[n] = BYTE_E2; n = n + 2'd1;
					e[n] = BYTE_81; n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			PH_IDLE: begin
				fresh       = 1'b1;
				fresh_first = start_q;
			end
			default: begin
				fresh = 1'b1;
			end
		endcase

		// Match the current byte again from idle.
		if (fresh) begin
			priority if (fresh_first && b == BYTE_EF) begin
				ph_mid = PH_MARK1;
			end else if (b == BYTE_CR) begin
				ph_mid = PH_CR;
			end else if (b == BYTE_C2) begin
				ph_mid = PH_C2;
			end else if (b == BYTE_E2) begin
				ph_mid = PH_E2;
			end else begin
				e[n] = b; n = n + 2'd1;
			end
		end

		// Flush held bytes at stream end; a held CR becomes LF.
		ph_n = ph_mid;
		if (last) begin
			unique case (ph_mid)
				PH_MARK1: begin e[n] = BYTE_EF; n = n + 2'd1; end
				PH_MARK2: begin
					e[n] = BYTE_EF; n = n + 2'd1;
					e[n] = BYTE_BB; n = n + 2'd1;
				end
				PH_CR:    begin e[n] = BYTE_LF; n = n + 2'd1; end
				PH_C2:    begin e[n] = BYTE_C2; n = n + 2'd1; end
				PH_E2:    begin e[n] = BYTE_E2; n = n + 2'd1; end
				PH_E280: begin
					e[n] = BYTE_E2; n = n + 2'd1;
					e[n] = BYTE_80; n = n + 2'd1;
				end
				PH_E281: begin
					e[n] = BYTE_E2; n = n + 2'd1;
					e[n] = BYTE_81; n = n + 2'd1;
				end
				default: ;
			endcase
			ph_n = PH_IDLE;
		end
	end

	// Drop groups that release nothing mid-stream.
	assign push           = accept && (n != 2'd0 || last);
	assign push_grp.bytes = e;
	assign push_grp.cnt   = n;
	assign push_grp.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= 1'b1;
		end else if (accept) begin
			phase_q <= ph_n;
			start_q <= last;
		end
	end

endmodule

// ===== hw/rtl/stn_queue.sv =====
// Short group queue between front and back ends.
// Depends on stn_pkg.
module stn_queue
	import stn_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  grp_t      push_grp,
	input  logic      pop,
	output grp_t      head,
	output q_status_t q_st
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	grp_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign head       = mem_q[rd_ptr_q];
	assign q_st.full  = (fill_q == CW'(DEPTH));
	assign q_st.empty = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + CW'(1);
				2'b01:   fill_q <= fill_q - CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/stn_back.sv =====
// Back end: walks the head group and sends one result per transaction.
// Depends on stn_pkg and stn_stream_if.
module stn_back
	import stn_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  grp_t          head,
	input  q_status_t     q_st,
	output logic          pop,
	stn_stream_if.source  out_ch
);

	logic [1:0] idx_q;
	logic       bare;
	logic       final_one;
	logic       xfer;

	assign bare      = (head.cnt == 2'd0);
	assign final_one = bare || (idx_q == head.cnt - 2'd1);
	assign xfer      = out_ch.valid && out_ch.ready;
	assign pop       = xfer && final_one;

	assign out_ch.valid           = !q_st.empty;
	assign out_ch.data.out_byte   = bare ? 8'h00 : head.bytes[idx_q];
	assign out_ch.data.out_valid  = !bare;
	assign out_ch.data.run_end    = final_one;
	assign out_ch.data.stream_end = final_one && head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (xfer) begin
			idx_q <= final_one ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== tb/sv/stn_normalizer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the source text normalizer: watches both channels, predicts, compares.
// Depends on stn_pkg for the transaction structs and byte constants.
module stn_normalizer_checker
	import stn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_data,
	output int unsigned mismatches,
	output int unsigned pending
);

	typedef enum logic [2:0] {
		HOLD_NONE,
		HOLD_EF,
		HOLD_EFBB,
		HOLD_CR,
		HOLD_C2,
		HOLD_E2,
		HOLD_E280,
		HOLD_E281
	} hold_t;

	hold_t      held = HOLD_NONE;
	logic       fresh_stream = 1'b1;
	logic [7:0] released[$];
	out_item_t  due_results[$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	// Match one byte from the idle phase.
	function automatic void rematch(input logic [7:0] b, input logic first);
		held = HOLD_NONE;
		if (first && b == BYTE_EF) begin
			held = HOLD_EF;
		end else if (b == BYTE_CR) begin
			held = HOLD_CR;
		end else if (b == BYTE_C2) begin
			held = HOLD_C2;
		end else if (b == BYTE_E2) begin
			held = HOLD_E2;
		end else begin
			released.push_back(b);
		end
	endfunction

	function automatic void flush_held();
		case (held)
			HOLD_EF: released.push_back(BYTE_EF);
			HOLD_EFBB: begin
				released.push_back(BYTE_EF);
				released.push_back(BYTE_BB);
			end
			HOLD_CR: released.push_back(BYTE_LF);
			HOLD_C2: released.push_back(BYTE_C2);
			HOLD_E2: released.push_back(BYTE_E2);
			HOLD_E280: begin
				released.push_back(BYTE_E2);
				released.push_back(BYTE_80);
			end
			HOLD_E281: begin
				released.push_back(BYTE_E2);
				released.push_back(BYTE_81);
			end
			default: ;
		endcase
		held = HOLD_NONE;
	endfunction

	task automatic normalize_byte(input in_item_t item);
		logic [7:0] b;
		logic       first;
		out_item_t  r;
		b     = item.in_byte;
		first = fresh_stream;
		fresh_stream = 1'b0;
		released.delete();
		case (held)
			HOLD_EF: begin
				if (b == BYTE_BB) begin
					held = HOLD_EFBB;
				end else begin
					released.push_back(BYTE_EF);
					rematch(b, 1'b0);
				end
			end
			HOLD_EFBB: begin
				if (b == BYTE_BF) begin
					held = HOLD_NONE;
				end else begin
					released.push_back(BYTE_EF);
					released.push_back(BYTE_BB);
					rematch(b, 1'b0);
				end
			end
			HOLD_CR: begin
				released.push_back(BYTE_LF);
				held = HOLD_NONE;
				if (b != BYTE_LF)
					rematch(b, 1'b0);
			end
			HOLD_C2: begin
				if (b == BYTE_A0) begin
					released.push_back(BYTE_SP);
					held = HOLD_NONE;
				end else begin
					released.push_back(BYTE_C2);
					rematch(b, 1'b0);
				end
			end
			HOLD_E2: begin
				if (b == BYTE_80) begin
					held = HOLD_E280;
				end else if (b == BYTE_81) begin
					held = HOLD_E281;
				end else begin
					released.push_back(BYTE_E2);
					rematch(b, 1'b0);
				end
			end
			HOLD_E280: begin
				if ((b >= BYTE_80 && b <= BYTE_8D) || b == BYTE_AF) begin
					released.push_back(BYTE_SP);
					held = HOLD_NONE;
				end else if (b == BYTE_A8 || b == BYTE_A9) begin
					released.push_back(BYTE_LF);
					held = HOLD_NONE;
				end else begin
					released.push_back(BYTE_E2);
					released.push_back(BYTE_80);
					rematch(b, 1'b0);
				end
			end
			HOLD_E281: begin
				if (b == BYTE_A0) begin
					released.push_back(BYTE_SP);
					held = HOLD_NONE;
				end else begin
					released.push_back(BYTE_E2);
					released.push_back(BYTE_81);
					rematch(b, 1'b0);
				end
			end
			default: rematch(b, first);
		endcase

		if (item.in_last) begin
			flush_held();
			fresh_stream = 1'b1;
		end

		// A completed mark on the last byte leaves only a bare end marker.
		if (released.size() == 0) begin
			if (item.in_last) begin
				r = '{out_byte: 8'h00, out_valid: 1'b0, run_end: 1'b1, stream_end: 1'b1};
				due_results.push_back(r);
			end
		end else begin
			for (int k = 0; k < released.size(); k++) begin
				r.out_byte   = released[k];
				r.out_valid  = 1'b1;
				r.run_end    = (k == released.size() - 1);
				r.stream_end = (k == released.size() - 1) && item.in_last;
				due_results.push_back(r);
			end
		end
	endtask

	task automatic note_failure(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s", $realtime, what);
	endtask

	// Values are stable from the falling edge to the next rising edge, so a
	// handshake seen here is the transaction taken at the coming rising edge.
	always @(negedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			held = HOLD_NONE;
			fresh_stream = 1'b1;
			due_results.delete();
		end else begin
			if (in_valid && in_ready)
				normalize_byte(in_data);
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					note_failure($sformatf("unexpected result byte=%02h valid=%0b run_end=%0b stream_end=%0b",
						out_data.out_byte, out_data.out_valid, out_data.run_end,
						out_data.stream_end));
				end else begin
					want = due_results.pop_front();
					if (out_data.out_byte !== want.out_byte || out_data.out_valid !== want.out_valid ||
						out_data.run_end !== want.run_end ||
						out_data.stream_end !== want.stream_end) begin
						note_failure($sformatf({"mismatch: got byte=%02h valid=%0b run_end=%0b ",
							"stream_end=%0b, want byte=%02h valid=%0b run_end=%0b stream_end=%0b"},
							out_data.out_byte, out_data.out_valid, out_data.run_end,
							out_data.stream_end, want.out_byte, want.out_valid, want.run_end,
							want.stream_end));
					end
				end
			end
		end
		pending = due_results.size();
	end

endmodule

// ===== tb/sv/tb_source_text_normalizer_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for source_text_normalizer_unit: clock, reset, stimulus and verdict.
// Depends on stn_pkg, stn_stream_if, the block itself and stn_normalizer_checker.
module tb_source_text_normalizer_unit;
	import stn_pkg::*;

	// Random part sized so directed plus random streams come to at least 321 bytes.
	localparam int unsigned RANDOM_ITEMS = 290;
	localparam int unsigned CALM_ITEMS   = 40;
	localparam int unsigned DRAIN_CYCLES = 24;
	// Cycles with no transaction on either channel before the run is abandoned.
	localparam int unsigned STALL_LIMIT  = 2000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	stn_stream_if #(.payload_t(in_item_t))  in_ch ();
	stn_stream_if #(.payload_t(out_item_t)) out_ch ();

	int unsigned mismatches;
	int unsigned pending;
	int unsigned quiet_cycles = 0;
	int unsigned directed_n;
	logic        calm = 1'b0;

	in_item_t    stim_q[$];
	logic [7:0]  line_bytes[$];

	always #6 clk = ~clk;

	source_text_normalizer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	stn_normalizer_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_data    (in_ch.data),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_data   (out_ch.data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Turn the collected bytes into one stream; the final byte carries in_last.
	function automatic void close_stream();
		for (int k = 0; k < line_bytes.size(); k++)
			stim_q.push_back('{in_byte: line_bytes[k], in_last: (k == line_bytes.size() - 1)});
		line_bytes.delete();
	endfunction

	// Append one piece of text: a raw byte or any sequence the
	// matcher knows, complete or broken off by an arbitrary byte.
	function automatic void add_token();
		logic [7:0] pick;
		case ($urandom_range(0, 15))
			0, 1, 2, 3: line_bytes.push_back(8'($urandom_range(0, 255)));
			4: line_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			5: line_bytes.push_back(BYTE_CR);
			6: begin
				line_bytes.push_back(BYTE_CR);
				line_bytes.push_back(BYTE_LF);
			end
			7: begin
				line_bytes.push_back(BYTE_C2);
				line_bytes.push_back(BYTE_A0);
			end
			8: begin
				line_bytes.push_back(BYTE_C2);
				line_bytes.push_back(8'($urandom_range(0, 255)));
			end
			9: begin
				line_bytes.push_back(BYTE_E2);
				line_bytes.push_back(BYTE_80);
				line_bytes.push_back(8'($urandom_range(BYTE_80, BYTE_8D)));
			end
			10: begin
				case ($urandom_range(0, 2))
					0: pick = BYTE_AF;
					1: pick = BYTE_A8;
					default: pick = BYTE_A9;
				endcase
				line_bytes.push_back(BYTE_E2);
				line_bytes.push_back(BYTE_80);
				line_bytes.push_back(pick);
			end
			11: begin
				line_bytes.push_back(BYTE_E2);
				line_bytes.push_back(BYTE_80);
				line_bytes.push_back(8'($urandom_range(0, 255)));
			end
			12: begin
				line_bytes.push_back(BYTE_E2);
				line_bytes.push_back(BYTE_81);
				line_bytes.push_back(BYTE_A0);
			end
			13: begin
				line_bytes.push_back(BYTE_E2);
				if ($urandom_range(0, 1))
					line_bytes.push_back(BYTE_81);
				line_bytes.push_back(8'($urandom_range(0, 255)));
			end
			14: begin
				// A mark in the middle of a stream is ordinary text.
				line_bytes.push_back(BYTE_EF);
				line_bytes.push_back(BYTE_BB);
				line_bytes.push_back(BYTE_BF);
			end
			default: line_bytes.push_back(BYTE_EF);
		endcase
	endfunction

	function automatic void build_stream();
		int unsigned n_tokens;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				line_bytes.push_back(BYTE_EF);
				line_bytes.push_back(BYTE_BB);
				line_bytes.push_back(BYTE_BF);
			end
			3: line_bytes.push_back(BYTE_EF);
			4: begin
				line_bytes.push_back(BYTE_EF);
				line_bytes.push_back(BYTE_BB);
			end
			5: begin
				// Nothing but the mark: the stream ends with a bare marker.
				line_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF};
				close_stream();
				return;
			end
			default: ;
		endcase
		n_tokens = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
		repeat (n_tokens)
			add_token();
		// Leave a prefix open at the last byte now and then, so it gets flushed.
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 4))
				0: line_bytes.push_back(BYTE_CR);
				1: line_bytes.push_back(BYTE_C2);
				2: line_bytes.push_back(BYTE_E2);
				3: begin
					line_bytes.push_back(BYTE_E2);
					line_bytes.push_back(BYTE_80);
				end
				default: begin
					line_bytes.push_back(BYTE_E2);
					line_bytes.push_back(BYTE_81);
				end
			endcase
		end
		close_stream();
	endfunction

	// Watchdog: count cycles in which no transaction moves on either channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts between ready runs;
	// hold ready high for good once the run is in its calm tail.
	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// Sender: directed streams, then random streams, then drain and verdict.
	initial begin
		int unsigned i;
		logic        took;
		logic        gappy;

		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		gappy = 1'b0;

		// Mark, CR LF and a lone CR held at the end.
		line_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF, BYTE_CR, BYTE_LF, BYTE_CR};
		close_stream();
		// Complete mark only: bare end marker.
		line_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF};
		close_stream();
		// Unfinished mark at the end.
		line_bytes = '{BYTE_EF, BYTE_BB};
		close_stream();
		// Byte extremes, mark byte mid-stream, C2 A0, broken C2, E2 held at the end.
		line_bytes = '{8'h00, 8'hFF, BYTE_EF, BYTE_C2, BYTE_A0, BYTE_C2, BYTE_C2, BYTE_A0,
			BYTE_E2};
		close_stream();
		// Three-byte spaces and line separator, E2 80 held at the end.
		line_bytes = '{BYTE_E2, BYTE_80, BYTE_8D, BYTE_E2, BYTE_80, BYTE_A8, BYTE_E2, BYTE_81,
			BYTE_A0, BYTE_E2, BYTE_80};
		close_stream();
		directed_n = stim_q.size();

		while (stim_q.size() < directed_n + RANDOM_ITEMS)
			build_stream();

		// Hold reset, then release it at a rising edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < stim_q.size(); i++) begin
			calm = (i + CALM_ITEMS >= stim_q.size());
			if (i % 50 == 0)
				gappy = ($urandom_range(0, 2) != 0);

			// Pause until every expected result has come, after the directed
			// part and once in the middle of the random part.
			if (i == directed_n || i == directed_n + RANDOM_ITEMS / 2) begin
				in_ch.valid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end

			if (!calm && gappy && $urandom_range(0, 3) == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end

			in_ch.valid <= 1'b1;
			in_ch.data  <= stim_q[i];
			// Sample ready at the falling edge, where it is settled, and
			// advance once the transaction is taken at the rising edge.
			do begin
				@(negedge clk);
				took = in_ch.ready;
				@(posedge clk);
			end while (!took);
		end
		in_ch.valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/stn_pkg.sv
hw/rtl/stn_stream_if.sv
hw/rtl/stn_front.sv
hw/rtl/stn_queue.sv
hw/rtl/stn_back.sv
hw/rtl/source_text_normalizer_unit.sv
tb/sv/stn_normalizer_checker.sv
tb/sv/tb_source_text_normalizer_unit.sv
